/* hw/rtl/cmt_pkg.sv */
// package for the compartment membership tracker
// holds event codes, membership bit positions, counter types and default sizes
// no dependencies
package cmt_pkg;

  localparam int unsigned MAX_PATIENTS_DEF = 1024;
  localparam int unsigned NUM_GROUPS_DEF   = 16;

  localparam int unsigned NBITS     = 4;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned NSTATES_W = 2;

  localparam logic [NSTATES_W-1:0] NSTATES_RESET = 2'd3;
  localparam logic [NSTATES_W-1:0] NSTATES_TWO   = 2'd2;

  // membership bit positions
  localparam logic [1:0] BIT_PRESENT     = 2'd0;
  localparam logic [1:0] BIT_SUSCEPTIBLE = 2'd1;
  localparam logic [1:0] BIT_LATENT      = 2'd2;
  localparam logic [1:0] BIT_COLONIZED   = 2'd3;

  typedef enum logic [2:0] {
    EV_ACQUIRE   = 3'd0,
    EV_PROGRESS  = 3'd1,
    EV_CLEAR     = 3'd2,
    EV_ADMIT_S   = 3'd3,
    EV_ADMIT_L   = 3'd4,
    EV_ADMIT_C   = 3'd5,
    EV_DISCHARGE = 3'd6,
    EV_NONE      = 3'd7
  } event_kind_e;

  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [NBITS-1:0]            member_t;
  typedef logic [NBITS-1:0][CNT_W-1:0] grp_cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef struct packed {
    logic        act;
    logic        grp_ok;
    logic        undo;
    logic        two_states;
    event_kind_e kind;
  } evt_ctrl_t;

endpackage

/* hw/rtl/cmt_update.sv */
// next-state logic for one event: new membership bits, flip masks and
// the updated saturating counters of the patient's group
// depends on cmt_pkg
module cmt_update import cmt_pkg::*; (
  input  evt_ctrl_t ctrl_i,
  input  member_t   bits_i,
  input  grp_cnt_t  grp_i,
  output member_t   bits_o,
  output member_t   set_o,
  output member_t   clr_o,
  output grp_cnt_t  grp_o
);

  logic [1:0] acq_bit;
  member_t    nxt;

  always_comb begin
    acq_bit = ctrl_i.two_states ? BIT_COLONIZED : BIT_LATENT;
    nxt     = bits_i;
    if (ctrl_i.act) begin
      if (!ctrl_i.undo) begin
        case (ctrl_i.kind)
          EV_ACQUIRE: begin
            nxt[BIT_SUSCEPTIBLE] = 1'b0;
            nxt[acq_bit]         = 1'b1;
          end
          EV_PROGRESS: begin
            nxt[BIT_LATENT]    = 1'b0;
            nxt[BIT_COLONIZED] = 1'b1;
          end
          EV_CLEAR: begin
            nxt[BIT_COLONIZED]   = 1'b0;
            nxt[BIT_SUSCEPTIBLE] = 1'b1;
          end
          EV_ADMIT_S: begin
            nxt[BIT_PRESENT]     = 1'b1;
            nxt[BIT_SUSCEPTIBLE] = 1'b1;
          end
          EV_ADMIT_L: begin
            nxt[BIT_PRESENT] = 1'b1;
            nxt[BIT_LATENT]  = 1'b1;
          end
          EV_ADMIT_C: begin
            nxt[BIT_PRESENT]   = 1'b1;
            nxt[BIT_COLONIZED] = 1'b1;
          end
          EV_DISCHARGE: nxt = '0;
          default: nxt = bits_i;
        endcase
      end else begin
        // only the compartment moves can be reversed
        case (ctrl_i.kind)
          EV_ACQUIRE: begin
            nxt[BIT_SUSCEPTIBLE] = 1'b1;
            nxt[acq_bit]         = 1'b0;
          end
          EV_PROGRESS: begin
            nxt[BIT_LATENT]    = 1'b1;
            nxt[BIT_COLONIZED] = 1'b0;
          end
          EV_CLEAR: begin
            nxt[BIT_COLONIZED]   = 1'b1;
            nxt[BIT_SUSCEPTIBLE] = 1'b0;
          end
          default: nxt = bits_i;
        endcase
      end
    end
  end

  assign bits_o = nxt;
  assign set_o  = nxt & ~bits_i;
  assign clr_o  = bits_i & ~nxt;

  // group counters saturate, since a patient may be given another group later
  always_comb begin
    for (int b = 0; b < NBITS; b++) begin
      grp_o[b] = grp_i[b];
      if (ctrl_i.grp_ok && set_o[b] && grp_i[b] != CNT_MAX) begin
        grp_o[b] = grp_i[b] + cnt_t'(1);
      end else if (ctrl_i.grp_ok && clr_o[b] && grp_i[b] != '0) begin
        grp_o[b] = grp_i[b] - cnt_t'(1);
      end
    end
  end

endmodule

/* hw/rtl/compartment_membership_tracker_top.sv */
// compartment membership tracker: top level with the membership and group memories
// depends on cmt_pkg and cmt_update
//
// usage:
//   an event is accepted at a rising edge with start high and busy low. its
//   fields are sampled at that edge. the result (overall counts and the
//   counts of query_group, all after the event) is registered at the end
//   of the update cycle that follows the accept and shown on the result
//   ports for exactly one cycle, marked by done_o. the receiver cannot stall.
//   one event at a time: busy is high in the cycle after each accept,
//   while the patient's membership entry and the group counters are read
//   from their memories, updated and written back. a new event can be
//   accepted in the cycle that shows the previous result.
//   the config channel (number of states) is always ready. write it only
//   while no event is in flight; the block itself does not enforce this.
//   after reset busy stays high while a pass zeroes every entry of both
//   memories, one entry a cycle. overall counts and the config register
//   reset directly.
module compartment_membership_tracker_top import cmt_pkg::*; #(
  parameter int unsigned MAX_PATIENTS = MAX_PATIENTS_DEF,
  parameter int unsigned NUM_GROUPS   = NUM_GROUPS_DEF,
  localparam int unsigned PID_W = $clog2(MAX_PATIENTS),
  localparam int unsigned GRP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode_i,
  input  logic [2:0]           event_kind_i,
  input  logic                 patient_present_i,
  input  logic [PID_W-1:0]     patient_id_i,
  input  logic [GRP_W-1:0]     patient_group_i,
  input  logic [GRP_W-1:0]     query_group_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [NSTATES_W-1:0] cfg_data_i,
  output logic                 done_o,
  output logic [CNT_W-1:0]     all_present_o,
  output logic [CNT_W-1:0]     all_susceptible_o,
  output logic [CNT_W-1:0]     all_latent_o,
  output logic [CNT_W-1:0]     all_colonized_o,
  output logic [CNT_W-1:0]     group_present_o,
  output logic [CNT_W-1:0]     group_susceptible_o,
  output logic [CNT_W-1:0]     group_latent_o,
  output logic [CNT_W-1:0]     group_colonized_o
);

  localparam int unsigned OC_W  = $clog2(MAX_PATIENTS + 1);
  localparam int unsigned CLR_N = (MAX_PATIENTS > NUM_GROUPS) ? MAX_PATIENTS : NUM_GROUPS;
  localparam int unsigned CLR_W = $clog2(CLR_N);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic [NSTATES_W-1:0] nstates_q;

  logic accept;

  // event registers
  logic              undo_q, act_q, grp_ok_q, q_ok_q, same_grp_q;
  event_kind_e       kind_q;
  logic [PID_W-1:0]  pid_q;
  logic [GRP_W-1:0]  pg_q;

  // memories and their read registers
  member_t  mem_q   [MAX_PATIENTS];
  grp_cnt_t grp_mem [NUM_GROUPS];
  member_t  mem_rd_q;
  grp_cnt_t pg_rd_q, qg_rd_q;

  logic             mem_we, grp_we;
  logic [PID_W-1:0] mem_wa;
  logic [GRP_W-1:0] grp_wa;
  member_t          mem_wd;
  grp_cnt_t         grp_wd;

  logic [OC_W-1:0] oc_q [NBITS];
  logic [OC_W-1:0] oc_d [NBITS];

  evt_ctrl_t ctrl;
  member_t   bits_new, set_m, clr_m;
  grp_cnt_t  grp_new, grp_rep;

  logic done_q;
  logic [CNT_W-1:0] all_q [NBITS];
  grp_cnt_t         grp_out_q;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // control
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      nstates_q <= NSTATES_RESET;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= (state_q == ST_EXEC);
      if (cfg_valid_i) nstates_q <= cfg_data_i;
    end
  end

  // sample the event and issue the memory reads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      undo_q     <= mode_i;
      kind_q     <= event_kind_e'(event_kind_i);
      act_q      <= patient_present_i && (32'(patient_id_i) < MAX_PATIENTS);
      grp_ok_q   <= (32'(patient_group_i) < NUM_GROUPS);
      q_ok_q     <= (32'(query_group_i) < NUM_GROUPS);
      same_grp_q <= (patient_group_i == query_group_i);
      pid_q      <= patient_id_i;
      pg_q       <= patient_group_i;
      mem_rd_q   <= mem_q[patient_id_i];
      pg_rd_q    <= grp_mem[patient_group_i];
      qg_rd_q    <= grp_mem[query_group_i];
    end
  end

  assign ctrl.act        = act_q;
  assign ctrl.grp_ok     = grp_ok_q;
  assign ctrl.undo       = undo_q;
  assign ctrl.two_states = (nstates_q == NSTATES_TWO);
  assign ctrl.kind       = kind_q;

  cmt_update u_update (
    .ctrl_i (ctrl),
    .bits_i (mem_rd_q),
    .grp_i  (pg_rd_q),
    .bits_o (bits_new),
    .set_o  (set_m),
    .clr_o  (clr_m),
    .grp_o  (grp_new)
  );

  // write back, or zero one entry a cycle during the clearing pass
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we = (32'(clr_q) < MAX_PATIENTS);
      mem_wa = clr_q[PID_W-1:0];
      mem_wd = '0;
      grp_we = (32'(clr_q) < NUM_GROUPS);
      grp_wa = clr_q[GRP_W-1:0];
      grp_wd = '0;
    end else begin
      mem_we = (state_q == ST_EXEC) && act_q;
      mem_wa = pid_q;
      mem_wd = bits_new;
      grp_we = (state_q == ST_EXEC) && act_q && grp_ok_q;
      grp_wa = pg_q;
      grp_wd = grp_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (grp_we) grp_mem[grp_wa] <= grp_wd;
  end

  // overall counts follow the bit flips
  always_comb begin
    for (int b = 0; b < NBITS; b++) begin
      oc_d[b] = oc_q[b];
      if (set_m[b]) begin
        oc_d[b] = oc_q[b] + OC_W'(1);
      end else if (clr_m[b] && oc_q[b] != '0) begin
        oc_d[b] = oc_q[b] - OC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NBITS; b++) oc_q[b] <= '0;
    end else if (state_q == ST_EXEC) begin
      for (int b = 0; b < NBITS; b++) oc_q[b] <= oc_d[b];
    end
  end

  // queried group sees this event's update when it is the patient's group
  always_comb begin
    if (!q_ok_q) begin
      grp_rep = '0;
    end else if (grp_ok_q && same_grp_q) begin
      grp_rep = grp_new;
    end else begin
      grp_rep = qg_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      for (int b = 0; b < NBITS; b++) all_q[b] <= CNT_W'(oc_d[b]);
      grp_out_q <= grp_rep;
    end
  end

  assign done_o              = done_q;
  assign all_present_o       = all_q[BIT_PRESENT];
  assign all_susceptible_o   = all_q[BIT_SUSCEPTIBLE];
  assign all_latent_o        = all_q[BIT_LATENT];
  assign all_colonized_o     = all_q[BIT_COLONIZED];
  assign group_present_o     = grp_out_q[BIT_PRESENT];
  assign group_susceptible_o = grp_out_q[BIT_SUSCEPTIBLE];
  assign group_latent_o      = grp_out_q[BIT_LATENT];
  assign group_colonized_o   = grp_out_q[BIT_COLONIZED];

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_EXEC))
    else $error("result strobe without a preceding update cycle");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC) && busy)
    else $error("accepted event did not enter the update cycle");

  a_write_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we || grp_we) |-> (state_q != ST_IDLE))
    else $error("memory write while idle");

  a_present_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(oc_q[BIT_PRESENT]) <= MAX_PATIENTS)
    else $error("present count above the number of patients");

endmodule

/* verif/tb.sv */
// self-checking testbench for compartment_membership_tracker_top
// depends on cmt_pkg and the tracker rtl; predicts every result and checks it field by field
module tb;
  import cmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPAT        = MAX_PATIENTS_DEF;
  localparam int unsigned NGRP        = NUM_GROUPS_DEF;
  localparam int unsigned POOL_SZ     = 24;
  localparam int unsigned CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic        undo;
    event_kind_e kind;
    logic        present;
    logic [9:0]  id;
    logic [3:0]  grp;
    logic [3:0]  qgrp;
  } event_t;

  // index by membership bit position: present, susceptible, latent, colonized
  typedef struct packed {
    grp_cnt_t overall;
    grp_cnt_t in_group;
  } tally_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 mode_i      = 1'b0;
  logic [2:0]           event_kind_i = EV_NONE;
  logic                 patient_present_i = 1'b0;
  logic [9:0]           patient_id_i    = '0;
  logic [3:0]           patient_group_i = '0;
  logic [3:0]           query_group_i   = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [NSTATES_W-1:0] cfg_data_i  = NSTATES_RESET;
  logic                 busy;
  logic                 cfg_ready_o;
  logic                 done_o;
  logic [CNT_W-1:0]     all_present_o, all_susceptible_o, all_latent_o, all_colonized_o;
  logic [CNT_W-1:0]     group_present_o, group_susceptible_o, group_latent_o;
  logic [CNT_W-1:0]     group_colonized_o;

  compartment_membership_tracker_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .mode_i              (mode_i),
    .event_kind_i        (event_kind_i),
    .patient_present_i   (patient_present_i),
    .patient_id_i        (patient_id_i),
    .patient_group_i     (patient_group_i),
    .query_group_i       (query_group_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .done_o              (done_o),
    .all_present_o       (all_present_o),
    .all_susceptible_o   (all_susceptible_o),
    .all_latent_o        (all_latent_o),
    .all_colonized_o     (all_colonized_o),
    .group_present_o     (group_present_o),
    .group_susceptible_o (group_susceptible_o),
    .group_latent_o      (group_latent_o),
    .group_colonized_o   (group_colonized_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted tracker state
  logic [NSTATES_W-1:0] states_cfg = NSTATES_RESET;
  member_t              member_bits[NPAT];
  grp_cnt_t             group_tally[NGRP];
  int unsigned          overall_tally[NBITS];

  event_t   pending_events[$];
  tally_t   expected_tally[$];
  event_t   cur_ev;
  int       outstanding   = 0;
  int       gap_left      = 0;
  bit       quiet         = 1'b0;
  int       errors        = 0;
  int       checked       = 0;
  int       undo_cnt      = 0;
  int       cfg_writes    = 0;
  int       cycles        = 0;
  logic [9:0] pool_ids[POOL_SZ];
  logic [3:0] home_group[NPAT];
  string    bit_names[NBITS] = '{"present", "susceptible", "latent", "colonized"};

  function automatic void flip_member(input logic [9:0] id, input logic [3:0] grp,
                                      input logic [1:0] b, input logic on);
    if (member_bits[id][b] == on) return;
    member_bits[id][b] = on;
    if (on) begin
      overall_tally[b]++;
      if (group_tally[grp][b] != CNT_MAX) group_tally[grp][b]++;
    end else begin
      if (overall_tally[b] != 0) overall_tally[b]--;
      if (group_tally[grp][b] != '0) group_tally[grp][b]--;
    end
  endfunction

  function automatic tally_t track_event(input event_t ev);
    logic [1:0] acq_bit;
    tally_t     t;
    acq_bit = (states_cfg == NSTATES_TWO) ? BIT_COLONIZED : BIT_LATENT;
    if (ev.present) begin
      if (!ev.undo) begin
        case (ev.kind)
          EV_ACQUIRE: begin
            flip_member(ev.id, ev.grp, BIT_SUSCEPTIBLE, 1'b0);
            flip_member(ev.id, ev.grp, acq_bit, 1'b1);
          end
          EV_PROGRESS: begin
            flip_member(ev.id, ev.grp, BIT_LATENT, 1'b0);
            flip_member(ev.id, ev.grp, BIT_COLONIZED, 1'b1);
          end
          EV_CLEAR: begin
            flip_member(ev.id, ev.grp, BIT_COLONIZED, 1'b0);
            flip_member(ev.id, ev.grp, BIT_SUSCEPTIBLE, 1'b1);
          end
          EV_ADMIT_S: begin
            flip_member(ev.id, ev.grp, BIT_PRESENT, 1'b1);
            flip_member(ev.id, ev.grp, BIT_SUSCEPTIBLE, 1'b1);
          end
          EV_ADMIT_L: begin
            flip_member(ev.id, ev.grp, BIT_PRESENT, 1'b1);
            flip_member(ev.id, ev.grp, BIT_LATENT, 1'b1);
          end
          EV_ADMIT_C: begin
            flip_member(ev.id, ev.grp, BIT_PRESENT, 1'b1);
            flip_member(ev.id, ev.grp, BIT_COLONIZED, 1'b1);
          end
          EV_DISCHARGE: begin
            flip_member(ev.id, ev.grp, BIT_SUSCEPTIBLE, 1'b0);
            flip_member(ev.id, ev.grp, BIT_COLONIZED, 1'b0);
            flip_member(ev.id, ev.grp, BIT_LATENT, 1'b0);
            flip_member(ev.id, ev.grp, BIT_PRESENT, 1'b0);
          end
          default: ;
        endcase
      end else begin
        // undo only reverses the three transitions
        case (ev.kind)
          EV_ACQUIRE: begin
            flip_member(ev.id, ev.grp, BIT_SUSCEPTIBLE, 1'b1);
            flip_member(ev.id, ev.grp, acq_bit, 1'b0);
          end
          EV_PROGRESS: begin
            flip_member(ev.id, ev.grp, BIT_LATENT, 1'b1);
            flip_member(ev.id, ev.grp, BIT_COLONIZED, 1'b0);
          end
          EV_CLEAR: begin
            flip_member(ev.id, ev.grp, BIT_COLONIZED, 1'b1);
            flip_member(ev.id, ev.grp, BIT_SUSCEPTIBLE, 1'b0);
          end
          default: ;
        endcase
      end
    end
    for (int b = 0; b < NBITS; b++) begin
      t.overall[b]  = overall_tally[b][CNT_W-1:0];
      t.in_group[b] = group_tally[ev.qgrp][b];
    end
    return t;
  endfunction

  task automatic queue_event(input logic undo, input event_kind_e kind, input logic present,
                             input logic [9:0] id, input logic [3:0] grp,
                             input logic [3:0] qgrp);
    event_t ev;
    ev = '{undo: undo, kind: kind, present: present, id: id, grp: grp, qgrp: qgrp};
    pending_events.push_back(ev);
    outstanding++;
  endtask

  // mostly lifecycles on a small set of patients, with some noise on top
  task automatic queue_random(input int n);
    event_t ev;
    int     roll;
    for (int i = 0; i < POOL_SZ; i++) pool_ids[i] = 10'($urandom_range(0, NPAT - 1));
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 14)      ev.kind = EV_ADMIT_S;
      else if (roll < 20) ev.kind = EV_ADMIT_L;
      else if (roll < 26) ev.kind = EV_ADMIT_C;
      else if (roll < 44) ev.kind = EV_ACQUIRE;
      else if (roll < 58) ev.kind = EV_PROGRESS;
      else if (roll < 72) ev.kind = EV_CLEAR;
      else if (roll < 84) ev.kind = EV_DISCHARGE;
      else if (roll < 90) ev.kind = EV_NONE;
      else                ev.kind = event_kind_e'($urandom_range(0, 7));
      ev.undo    = ($urandom_range(0, 4) == 0);
      ev.present = ($urandom_range(0, 14) != 0);
      ev.id      = ($urandom_range(0, 6) != 0) ? pool_ids[$urandom_range(0, POOL_SZ - 1)]
                                               : 10'($urandom_range(0, NPAT - 1));
      // an occasional wrong group drives the group counters against their clamp at zero
      ev.grp     = ($urandom_range(0, 11) != 0) ? home_group[ev.id]
                                                : 4'($urandom_range(0, NGRP - 1));
      ev.qgrp    = ($urandom_range(0, 4) < 3) ? home_group[ev.id]
                                              : 4'($urandom_range(0, NGRP - 1));
      queue_event(ev.undo, ev.kind, ev.present, ev.id, ev.grp, ev.qgrp);
    end
  endtask

  task automatic drain();
    wait (outstanding == 0);
    @(posedge clk_i);
  endtask

  task automatic set_states(input logic [NSTATES_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    states_cfg = value;
    cfg_writes++;
  endtask

  // event driver: one event per transfer, random idle bursts between events unless quiet is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_tally.push_back(track_event(cur_ev));
        if (cur_ev.undo) undo_cnt++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_events.size() > 0) begin
          cur_ev = pending_events.pop_front();
          mode_i            <= cur_ev.undo;
          event_kind_i      <= cur_ev.kind;
          patient_present_i <= cur_ev.present;
          patient_id_i      <= cur_ev.id;
          patient_group_i   <= cur_ev.grp;
          query_group_i     <= cur_ev.qgrp;
          start             <= 1'b1;
          if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tally_t want, got;
    if (rst_ni && done_o) begin
      if (expected_tally.size() == 0) begin
        errors++;
        $display("%0t: result with no event outstanding", $time);
      end else begin
        want = expected_tally.pop_front();
        outstanding--;
        checked++;
        got.overall  = {all_colonized_o, all_latent_o, all_susceptible_o, all_present_o};
        got.in_group = {group_colonized_o, group_latent_o, group_susceptible_o,
                        group_present_o};
        for (int b = 0; b < NBITS; b++) begin
          if (got.overall[b] !== want.overall[b]) begin
            errors++;
            $display("%0t: all_%s expected %0d actual %0d", $time, bit_names[b],
                     want.overall[b], got.overall[b]);
          end
          if (got.in_group[b] !== want.in_group[b]) begin
            errors++;
            $display("%0t: group_%s expected %0d actual %0d", $time, bit_names[b],
                     want.in_group[b], got.in_group[b]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycles, outstanding);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NPAT; i++) begin
      member_bits[i] = '0;
      home_group[i]  = 4'($urandom_range(0, NGRP - 1));
    end
    for (int g = 0; g < NGRP; g++) group_tally[g] = '0;
    for (int b = 0; b < NBITS; b++) overall_tally[b] = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed events at the reset setting (acquisition goes to latent)
    queue_event(1'b0, EV_ADMIT_S,   1'b0, 10'd5,    4'd1,  4'd1);
    queue_event(1'b0, EV_ADMIT_S,   1'b1, 10'd0,    4'd0,  4'd0);
    queue_event(1'b0, EV_ADMIT_L,   1'b1, 10'd1023, 4'd15, 4'd15);
    queue_event(1'b0, EV_ADMIT_C,   1'b1, 10'd512,  4'd5,  4'd5);
    queue_event(1'b0, EV_ACQUIRE,   1'b1, 10'd0,    4'd0,  4'd0);
    queue_event(1'b0, EV_PROGRESS,  1'b1, 10'd0,    4'd0,  4'd0);
    queue_event(1'b0, EV_CLEAR,     1'b1, 10'd0,    4'd0,  4'd0);
    queue_event(1'b1, EV_CLEAR,     1'b1, 10'd0,    4'd0,  4'd0);
    queue_event(1'b1, EV_PROGRESS,  1'b1, 10'd0,    4'd0,  4'd0);
    queue_event(1'b1, EV_ACQUIRE,   1'b1, 10'd0,    4'd0,  4'd15);
    queue_event(1'b0, EV_ADMIT_S,   1'b1, 10'd0,    4'd0,  4'd0);
    // transitions do not look at presence
    queue_event(1'b0, EV_ACQUIRE,   1'b1, 10'd7,    4'd3,  4'd3);
    queue_event(1'b0, EV_DISCHARGE, 1'b1, 10'd7,    4'd3,  4'd3);
    queue_event(1'b0, EV_DISCHARGE, 1'b1, 10'd1023, 4'd15, 4'd15);
    queue_event(1'b0, EV_DISCHARGE, 1'b1, 10'd1023, 4'd15, 4'd15);
    queue_event(1'b1, EV_ADMIT_C,   1'b1, 10'd512,  4'd5,  4'd5);
    queue_event(1'b1, EV_DISCHARGE, 1'b1, 10'd512,  4'd5,  4'd5);
    queue_event(1'b1, EV_NONE,      1'b1, 10'd0,    4'd0,  4'd0);
    queue_event(1'b0, EV_NONE,      1'b1, 10'd0,    4'd0,  4'd5);
    // same patient seen under two groups: the second group clamps at zero
    queue_event(1'b0, EV_ADMIT_S,   1'b1, 10'd300,  4'd2,  4'd2);
    queue_event(1'b0, EV_DISCHARGE, 1'b1, 10'd300,  4'd9,  4'd9);
    queue_event(1'b0, EV_DISCHARGE, 1'b0, 10'd512,  4'd5,  4'd5);
    drain();

    // two states: acquisition goes straight to colonized
    set_states(NSTATES_TWO);
    queue_event(1'b0, EV_ADMIT_S,   1'b1, 10'd40,   4'd10, 4'd10);
    queue_event(1'b0, EV_ACQUIRE,   1'b1, 10'd40,   4'd10, 4'd10);
    queue_event(1'b1, EV_ACQUIRE,   1'b1, 10'd40,   4'd10, 4'd10);
    queue_random(200);
    drain();

    set_states(2'd0);
    queue_random(200);
    drain();

    set_states(2'd1);
    queue_random(150);
    drain();

    set_states(2'd3);
    queue_random(200);
    drain();

    set_states(NSTATES_TWO);
    queue_random(150);
    drain();

    // closing stretch at full rate
    quiet = 1'b1;
    set_states(2'd3);
    queue_random(150);
    drain();

    repeat (4) @(posedge clk_i);
    $display("checked %0d results (%0d undo events) across %0d writes of number_of_states",
             checked, undo_cnt, cfg_writes);
    if (errors == 0 && expected_tally.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_tally.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* compartment_membership_tracker_top.f */
hw/rtl/cmt_pkg.sv
hw/rtl/cmt_update.sv
hw/rtl/compartment_membership_tracker_top.sv
verif/tb.sv
